[src/kot_pkg.sv]
// Shared types, token codes and character tables for the keyword/operator tokenizer.
`timescale 1ns / 1ps

package kot_pkg;

    // Default sizing
    localparam int KOT_VALUE_BITS   = 32;
    localparam int KOT_PREFIX_CHARS = 5;
    localparam int KOT_LENGTH_BITS  = 16;
    localparam int KOT_QUEUE_DEPTH  = 4;

    // Token codes
    localparam logic [4:0] TOK_NONE    = 5'd0;
    localparam logic [4:0] TOK_FOR     = 5'd1;
    localparam logic [4:0] TOK_IF      = 5'd2;
    localparam logic [4:0] TOK_THEN    = 5'd3;
    localparam logic [4:0] TOK_ELSE    = 5'd4;
    localparam logic [4:0] TOK_WHILE   = 5'd5;
    localparam logic [4:0] TOK_DO      = 5'd6;
    localparam logic [4:0] TOK_IDENT   = 5'd10;
    localparam logic [4:0] TOK_NUMBER  = 5'd11;
    localparam logic [4:0] TOK_HASH    = 5'd12;
    localparam logic [4:0] TOK_PLUS    = 5'd13;
    localparam logic [4:0] TOK_MINUS   = 5'd14;
    localparam logic [4:0] TOK_STAR    = 5'd15;
    localparam logic [4:0] TOK_SLASH   = 5'd16;
    localparam logic [4:0] TOK_COLON   = 5'd17;
    localparam logic [4:0] TOK_ASSIGN  = 5'd18;
    localparam logic [4:0] TOK_LT      = 5'd19;
    localparam logic [4:0] TOK_NE      = 5'd20;
    localparam logic [4:0] TOK_LE      = 5'd21;
    localparam logic [4:0] TOK_GT      = 5'd22;
    localparam logic [4:0] TOK_GE      = 5'd23;
    localparam logic [4:0] TOK_EQ      = 5'd24;
    localparam logic [4:0] TOK_SEMI    = 5'd25;
    localparam logic [4:0] TOK_LPAREN  = 5'd26;
    localparam logic [4:0] TOK_RPAREN  = 5'd27;

    // Characters
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // Keyword table: text right-justified, one byte per character
    localparam int KW_COUNT   = 6;
    localparam int KW_MAX_LEN = 5;
    localparam logic [KW_MAX_LEN*8-1:0] KW_FOR_TEXT   = 40'("for");
    localparam logic [KW_MAX_LEN*8-1:0] KW_IF_TEXT    = 40'("if");
    localparam logic [KW_MAX_LEN*8-1:0] KW_THEN_TEXT  = 40'("then");
    localparam logic [KW_MAX_LEN*8-1:0] KW_ELSE_TEXT  = 40'("else");
    localparam logic [KW_MAX_LEN*8-1:0] KW_WHILE_TEXT = 40'("while");
    localparam logic [KW_MAX_LEN*8-1:0] KW_DO_TEXT    = 40'("do");

    // Operator held over for one character to look for a pair
    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_COLON   = 2'd1,
        PEND_LESS    = 2'd2,
        PEND_GREATER = 2'd3
    } pend_t;

    // Input request
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } kot_in_t;

    // Result request
    typedef struct packed {
        logic [4:0]  token_code;
        logic [31:0] number_value;
        logic        number_saturated;
        logic [15:0] word_length;
        logic        last_of_run;
    } kot_out_t;

    // One token without the run marker
    typedef struct packed {
        logic [4:0]  token_code;
        logic [31:0] number_value;
        logic        number_saturated;
        logic [15:0] word_length;
    } kot_tok_t;

    // Queue entry: every token that one input request causes
    typedef struct packed {
        kot_tok_t   first;
        logic       has_second;
        logic [4:0] second_code;
    } kot_entry_t;

    function automatic int unsigned kw_len(input int unsigned k);
        int unsigned n;
        case (k)
            0:       n = 3;
            1:       n = 2;
            2:       n = 4;
            3:       n = 4;
            4:       n = 5;
            default: n = 2;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] kw_code(input int unsigned k);
        logic [4:0] code;
        case (k)
            0:       code = TOK_FOR;
            1:       code = TOK_IF;
            2:       code = TOK_THEN;
            3:       code = TOK_ELSE;
            4:       code = TOK_WHILE;
            default: code = TOK_DO;
        endcase
        return code;
    endfunction

    // Character j (from the start) of keyword k
    function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned j);
        logic [KW_MAX_LEN*8-1:0] text;
        case (k)
            0:       text = KW_FOR_TEXT;
            1:       text = KW_IF_TEXT;
            2:       text = KW_THEN_TEXT;
            3:       text = KW_ELSE_TEXT;
            4:       text = KW_WHILE_TEXT;
            default: text = KW_DO_TEXT;
        endcase
        return text[(kw_len(k) - 1 - j) * 8 +: 8];
    endfunction

    // Single-character operator code, TOK_NONE for anything else
    function automatic logic [4:0] single_code(input logic [7:0] c);
        logic [4:0] code;
        unique case (c)
            CH_HASH:    code = TOK_HASH;
            CH_PLUS:    code = TOK_PLUS;
            CH_MINUS:   code = TOK_MINUS;
            CH_STAR:    code = TOK_STAR;
            CH_SLASH:   code = TOK_SLASH;
            CH_COLON:   code = TOK_COLON;
            CH_LESS:    code = TOK_LT;
            CH_GREATER: code = TOK_GT;
            CH_EQUAL:   code = TOK_EQ;
            CH_SEMI:    code = TOK_SEMI;
            CH_LPAREN:  code = TOK_LPAREN;
            CH_RPAREN:  code = TOK_RPAREN;
            default:    code = TOK_NONE;
        endcase
        return code;
    endfunction

    // Operators that may open a two-character pair
    function automatic pend_t pend_of(input logic [7:0] c);
        pend_t p;
        unique case (c)
            CH_COLON:   p = PEND_COLON;
            CH_LESS:    p = PEND_LESS;
            CH_GREATER: p = PEND_GREATER;
            default:    p = PEND_NONE;
        endcase
        return p;
    endfunction

    function automatic logic [4:0] pend_code(input pend_t p);
        logic [4:0] code;
        unique case (p)
            PEND_COLON: code = TOK_COLON;
            PEND_LESS:  code = TOK_LT;
            default:    code = TOK_GT;
        endcase
        return code;
    endfunction

    // Two-character operator formed by a held operator and c, TOK_NONE if none
    function automatic logic [4:0] pair_code(input pend_t p, input logic [7:0] c);
        logic [4:0] code;
        code = TOK_NONE;
        if (p == PEND_COLON && c == CH_EQUAL)
            code = TOK_ASSIGN;
        else if (p == PEND_LESS && c == CH_GREATER)
            code = TOK_NE;
        else if (p == PEND_LESS && c == CH_EQUAL)
            code = TOK_LE;
        else if (p == PEND_GREATER && c == CH_EQUAL)
            code = TOK_GE;
        return code;
    endfunction

    function automatic kot_tok_t op_tok(input logic [4:0] code);
        kot_tok_t t;
        t.token_code       = code;
        t.number_value     = '0;
        t.number_saturated = 1'b0;
        t.word_length      = '0;
        return t;
    endfunction

endpackage

[src/keyword_operator_tokenizer.sv]
// A character's first token is queued when the character is accepted, then loaded into the output
// register; tok_valid is high from then on. One character per cycle while the queue is
// not full; a character that yields two tokens holds the output register for both, and
// the four-entry queue between front and back absorbs bursts. Sustained rate is bounded
// by the single output register: one token per cycle while tok_ready is high.
// Reset: rst_n is asynchronous, active low; it clears the word state, held operator,
// queue pointers and output valid. No clearing pass is needed.
`timescale 1ns / 1ps

module keyword_operator_tokenizer
    import kot_pkg::*;
#(
    parameter int VALUE_BITS   = KOT_VALUE_BITS,
    parameter int PREFIX_CHARS = KOT_PREFIX_CHARS,
    parameter int LENGTH_BITS  = KOT_LENGTH_BITS,
    parameter int QUEUE_DEPTH  = KOT_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_ready,
    input  kot_in_t  src_data,
    output logic     tok_valid,
    input  logic     tok_ready,
    output kot_out_t tok_data
);

    logic       q_full;
    logic       q_push;
    kot_entry_t q_push_entry;
    logic       q_pop;
    logic       q_nonempty;
    kot_entry_t q_head;

    // Character intake and classification
    kot_front #(
        .VALUE_BITS   (VALUE_BITS),
        .PREFIX_CHARS (PREFIX_CHARS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .full      (q_full),
        .push      (q_push),
        .entry     (q_push_entry)
    );

    // Decoupling queue
    kot_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .nonempty   (q_nonempty),
        .head       (q_head)
    );

    // Token output
    kot_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_data   (tok_data)
    );

endmodule

[src/kot_front.sv]
// Front end: accepts characters, builds words, classifies tokens and queues them.
`timescale 1ns / 1ps

module kot_front
    import kot_pkg::*;
#(
    parameter int VALUE_BITS   = KOT_VALUE_BITS,
    parameter int PREFIX_CHARS = KOT_PREFIX_CHARS,
    parameter int LENGTH_BITS  = KOT_LENGTH_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_ready,
    input  kot_in_t    src_data,
    input  logic       full,
    output logic       push,
    output kot_entry_t entry
);

    localparam logic [VALUE_BITS-1:0]  VALUE_MAX  = '1;
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

    // Word state
    pend_t                   pend_reg, pend_next;
    logic [LENGTH_BITS-1:0]  count_reg, count_next;
    logic                    digits_reg, digits_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic                    clamped_reg, clamped_next;
    logic [7:0]              prefix_reg [PREFIX_CHARS];

    logic                    accept;
    logic [7:0]              c;
    logic [4:0]              op_c;
    pend_t                   start_c;
    logic [4:0]              pair_c;
    logic                    is_delim;
    logic                    nonempty;

    logic                    kw_hit;
    logic [4:0]              kw_sel;
    logic                    kw_match;
    kot_tok_t                word_tok;
    logic [VALUE_BITS+31:0]  acc_wide;
    logic [LENGTH_BITS+15:0] count_wide;

    logic                    a_valid, b_valid, use_char, word_clear, char_add;
    kot_tok_t                a_tok;

    logic                    is_digit;
    logic [VALUE_BITS+3:0]   acc_ext, acc_times10;
    logic                    overflow;

    assign src_ready = !full;
    assign accept    = src_valid && !full;
    assign c         = src_data.char_code;
    assign op_c      = single_code(c);
    assign start_c   = pend_of(c);
    assign pair_c    = pair_code(pend_reg, c);
    assign is_delim  = (c == CH_SPACE) || (c == CH_CR) || (c == CH_LF);
    assign nonempty  = (count_reg != '0);

    // Keyword compare over the stored prefix, all keywords in parallel
    always_comb
    begin
        kw_hit = 1'b0;
        kw_sel = TOK_IDENT;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            kw_match = (count_reg == LENGTH_BITS'(kw_len(k)));
            for (int j = 0; j < KW_MAX_LEN; j++)
            begin
                if (j < kw_len(k) && prefix_reg[j] != kw_char(k, j))
                    kw_match = 1'b0;
            end
            if (kw_match)
            begin
                kw_hit = 1'b1;
                kw_sel = kw_code(k);
            end
        end
    end

    // Token for the word collected so far
    assign acc_wide   = {32'b0, acc_reg};
    assign count_wide = {16'b0, count_reg};

    always_comb
    begin
        word_tok.word_length = count_wide[15:0];
        if (kw_hit)
        begin
            word_tok.token_code       = kw_sel;
            word_tok.number_value     = '0;
            word_tok.number_saturated = 1'b0;
        end
        else if (digits_reg)
        begin
            word_tok.token_code       = TOK_NUMBER;
            word_tok.number_value     = acc_wide[31:0];
            word_tok.number_saturated = clamped_reg;
        end
        else
        begin
            word_tok.token_code       = TOK_IDENT;
            word_tok.number_value     = '0;
            word_tok.number_saturated = 1'b0;
        end
    end

    // Classify the request: held operator or word first, then a new operator
    always_comb
    begin
        pend_next  = pend_reg;
        a_valid    = 1'b0;
        a_tok      = word_tok;
        b_valid    = 1'b0;
        use_char   = 1'b1;
        word_clear = 1'b0;
        char_add   = 1'b0;
        if (src_data.end_of_text)
        begin
            word_clear = 1'b1;
            pend_next  = PEND_NONE;
            if (pend_reg != PEND_NONE)
            begin
                a_valid = 1'b1;
                a_tok   = op_tok(pend_code(pend_reg));
            end
            else
                a_valid = nonempty;
        end
        else
        begin
            // A held operator always leaves the word empty
            if (pend_reg != PEND_NONE)
            begin
                a_valid   = 1'b1;
                pend_next = PEND_NONE;
                if (pair_c != TOK_NONE)
                begin
                    a_tok    = op_tok(pair_c);
                    use_char = 1'b0;
                end
                else
                    a_tok = op_tok(pend_code(pend_reg));
            end
            if (use_char)
            begin
                if (op_c != TOK_NONE)
                begin
                    a_valid    = a_valid | nonempty;
                    word_clear = 1'b1;
                    if (start_c != PEND_NONE)
                        pend_next = start_c;
                    else
                        b_valid = 1'b1;
                end
                else if (is_delim)
                begin
                    a_valid    = a_valid | nonempty;
                    word_clear = 1'b1;
                end
                else
                    char_add = 1'b1;
            end
        end
    end

    assign push              = accept && (a_valid || b_valid);
    assign entry.first       = a_valid ? a_tok : op_tok(op_c);
    assign entry.has_second  = a_valid && b_valid;
    assign entry.second_code = op_c;

    // Decimal accumulate: acc * 10 + digit, saturating
    assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
    assign acc_ext     = {4'b0, acc_reg};
    assign acc_times10 = (acc_ext << 3) + (acc_ext << 1)
                         + (VALUE_BITS + 4)'(c[3:0]);
    assign overflow    = (acc_times10[VALUE_BITS+3:VALUE_BITS] != 4'b0);

    always_comb
    begin
        count_next   = count_reg;
        digits_next  = digits_reg;
        acc_next     = acc_reg;
        clamped_next = clamped_reg;
        if (word_clear)
        begin
            count_next   = '0;
            digits_next  = 1'b1;
            acc_next     = '0;
            clamped_next = 1'b0;
        end
        else if (char_add)
        begin
            if (count_reg != LENGTH_MAX)
                count_next = count_reg + 1'b1;
            if (!is_digit)
                digits_next = 1'b0;
            else if (digits_reg)
            begin
                if (clamped_reg || overflow)
                begin
                    acc_next     = VALUE_MAX;
                    clamped_next = 1'b1;
                end
                else
                    acc_next = acc_times10[VALUE_BITS-1:0];
            end
        end
    end

    // Control and word registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= PEND_NONE;
            count_reg   <= '0;
            digits_reg  <= 1'b1;
            acc_reg     <= '0;
            clamped_reg <= 1'b0;
        end
        else if (accept)
        begin
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            digits_reg  <= digits_next;
            acc_reg     <= acc_next;
            clamped_reg <= clamped_next;
        end
    end

    // First characters of the word, for the keyword compare
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PREFIX_CHARS; i++)
        begin
            if (accept && char_add && count_reg == LENGTH_BITS'(i))
                prefix_reg[i] <= c;
        end
    end

`ifndef SYNTHESIS
    // A held operator is only ever set after the word was flushed
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != PEND_NONE |-> count_reg == '0)
        else $error("operator held while a word is open");

    // The saturation flag always comes with the maximum value
    assert property (@(posedge clk) disable iff (!rst_n)
        clamped_reg |-> acc_reg == VALUE_MAX)
        else $error("saturation flag out of step with accumulator");
`endif

endmodule

[src/kot_queue.sv]
// Small request queue between the classifying front end and the output back end.
`timescale 1ns / 1ps

module kot_queue
    import kot_pkg::*;
#(
    parameter int DEPTH = KOT_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  kot_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       nonempty,
    output kot_entry_t head
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    kot_entry_t            slot_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_reg, wr_next;
    logic [PTR_BITS-1:0]   rd_reg, rd_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = slot_reg[rd_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
            wr_next = (wr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (pop)
            rd_next = (rd_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_entry;
    end

`ifndef SYNTHESIS
    // Front end honors the full flag
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != CNT_BITS'(DEPTH))
        else $error("push into full queue");

    // Back end only pops what is there
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");
`endif

endmodule

[src/kot_back.sv]
// Back end: splits queued entries into single tokens and drives the output register.
`timescale 1ns / 1ps

module kot_back
    import kot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_nonempty,
    input  kot_entry_t q_head,
    output logic       q_pop,
    output logic       tok_valid,
    input  logic       tok_ready,
    output kot_out_t   tok_data
);

    logic     out_valid_reg, out_valid_next;
    logic     phase_reg, phase_next;
    kot_out_t out_reg, out_next;
    logic     load;

    // Load a new token whenever the output register is free or being taken
    assign load  = q_nonempty && (!out_valid_reg || tok_ready);
    assign q_pop = load && (phase_reg || !q_head.has_second);

    always_comb
    begin
        if (phase_reg)
        begin
            out_next.token_code       = q_head.second_code;
            out_next.number_value     = '0;
            out_next.number_saturated = 1'b0;
            out_next.word_length      = '0;
            out_next.last_of_run      = 1'b1;
        end
        else
        begin
            out_next.token_code       = q_head.first.token_code;
            out_next.number_value     = q_head.first.number_value;
            out_next.number_saturated = q_head.first.number_saturated;
            out_next.word_length      = q_head.first.word_length;
            out_next.last_of_run      = !q_head.has_second;
        end
        out_valid_next = load || (out_valid_reg && !tok_ready);
        phase_next     = load ? (!phase_reg && q_head.has_second) : phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    assign tok_valid = out_valid_reg;
    assign tok_data  = out_reg;

`ifndef SYNTHESIS
    // While the second token of an entry is owed, that entry stays at the head
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> q_nonempty && q_head.has_second)
        else $error("second token owed but entry gone");
`endif

endmodule

[test/keyword_operator_tokenizer_check.sv]
// Checker for the tokenizer: predicts tokens from accepted characters and compares results.
`timescale 1ns / 1ps

module keyword_operator_tokenizer_check
    import kot_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    input  logic     src_ready,
    input  kot_in_t  src_data,
    input  logic     tok_valid,
    input  logic     tok_ready,
    input  kot_out_t tok_data,
    output int       fail_count,
    output int       tokens_due
);

    localparam logic [31:0] VALUE_LIMIT  = '1;
    localparam logic [15:0] LENGTH_LIMIT = '1;

    string      kw_spelling [KW_COUNT] = '{"for", "if", "then", "else", "while", "do"};
    logic [4:0] kw_token    [KW_COUNT] = '{TOK_FOR, TOK_IF, TOK_THEN, TOK_ELSE, TOK_WHILE,
                                           TOK_DO};

    // Lexer state of the prediction
    pend_t       held_op;
    logic [7:0]  word_head [KOT_PREFIX_CHARS];
    logic [15:0] word_len;
    logic        all_digits;
    logic [31:0] word_value;
    logic        value_sat;

    kot_out_t predicted_tokens [$];
    kot_out_t step_tokens [$];
    int       mismatches = 0;

    function void clear_word();
        foreach (word_head[i])
            word_head[i] = 8'd0;
        word_len   = '0;
        all_digits = 1'b1;
        word_value = '0;
        value_sat  = 1'b0;
    endfunction

    function void push_token(logic [4:0] code, logic [31:0] value, logic sat,
                             logic [15:0] len);
        kot_out_t t;
        t.token_code       = code;
        t.number_value     = value;
        t.number_saturated = sat;
        t.word_length      = len;
        t.last_of_run      = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function logic [4:0] operator_code(logic [7:0] c);
        logic [4:0] code;
        case (c)
            CH_HASH:    code = TOK_HASH;
            CH_PLUS:    code = TOK_PLUS;
            CH_MINUS:   code = TOK_MINUS;
            CH_STAR:    code = TOK_STAR;
            CH_SLASH:   code = TOK_SLASH;
            CH_COLON:   code = TOK_COLON;
            CH_LESS:    code = TOK_LT;
            CH_GREATER: code = TOK_GT;
            CH_EQUAL:   code = TOK_EQ;
            CH_SEMI:    code = TOK_SEMI;
            CH_LPAREN:  code = TOK_LPAREN;
            CH_RPAREN:  code = TOK_RPAREN;
            default:    code = TOK_NONE;
        endcase
        return code;
    endfunction

    function logic [4:0] held_code(pend_t p);
        logic [4:0] code;
        case (p)
            PEND_COLON: code = TOK_COLON;
            PEND_LESS:  code = TOK_LT;
            default:    code = TOK_GT;
        endcase
        return code;
    endfunction

    // Close the current word: keyword, number or identifier
    function void finish_word();
        logic [4:0] code;
        logic       hit;
        if (word_len == 0)
            return;
        code = all_digits ? TOK_NUMBER : TOK_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (word_len == kw_spelling[i].len()) begin
                hit = 1'b1;
                for (int j = 0; j < kw_spelling[i].len(); j++)
                    if (word_head[j] != kw_spelling[i][j])
                        hit = 1'b0;
                if (hit)
                    code = kw_token[i];
            end
        end
        if (code == TOK_NUMBER)
            push_token(code, word_value, value_sat, word_len);
        else
            push_token(code, '0, 1'b0, word_len);
        clear_word();
    endfunction

    // Add one word character; length and value both saturate
    function void append_char(logic [7:0] c);
        logic [63:0] digit;
        if (word_len < KOT_PREFIX_CHARS)
            word_head[word_len] = c;
        if (word_len != LENGTH_LIMIT)
            word_len++;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (all_digits) begin
                digit = 64'(c - CH_ZERO);
                if (value_sat || 64'(word_value) > (64'(VALUE_LIMIT) - digit) / 10) begin
                    word_value = VALUE_LIMIT;
                    value_sat  = 1'b1;
                end
                else
                    word_value = 32'(64'(word_value) * 10 + digit);
            end
        end
        else
            all_digits = 1'b0;
    endfunction

    // Tokens caused by one accepted character request
    function void lex_request(kot_in_t r);
        logic [4:0] pair;
        logic [4:0] op;
        logic [7:0] c;
        step_tokens.delete();
        c = r.char_code;
        if (r.end_of_text) begin
            if (held_op != PEND_NONE)
                push_token(held_code(held_op), '0, 1'b0, '0);
            held_op = PEND_NONE;
            finish_word();
            clear_word();
        end
        else begin
            pair = TOK_NONE;
            // resolve a held operator first
            if (held_op != PEND_NONE) begin
                if (held_op == PEND_COLON && c == CH_EQUAL)
                    pair = TOK_ASSIGN;
                else if (held_op == PEND_LESS && c == CH_GREATER)
                    pair = TOK_NE;
                else if (held_op == PEND_LESS && c == CH_EQUAL)
                    pair = TOK_LE;
                else if (held_op == PEND_GREATER && c == CH_EQUAL)
                    pair = TOK_GE;
                push_token((pair != TOK_NONE) ? pair : held_code(held_op), '0, 1'b0, '0);
                held_op = PEND_NONE;
            end
            if (pair == TOK_NONE) begin
                op = operator_code(c);
                if (op != TOK_NONE) begin
                    finish_word();
                    case (c)
                        CH_COLON:   held_op = PEND_COLON;
                        CH_LESS:    held_op = PEND_LESS;
                        CH_GREATER: held_op = PEND_GREATER;
                        default:    push_token(op, '0, 1'b0, '0);
                    endcase
                end
                else if (c == CH_SPACE || c == CH_CR || c == CH_LF)
                    finish_word();
                else
                    append_char(c);
            end
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
        foreach (step_tokens[i])
            predicted_tokens.push_back(step_tokens[i]);
    endfunction

    task check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    initial
    begin
        held_op = PEND_NONE;
        clear_word();
        fail_count = 0;
        tokens_due = 0;
    end

    // Watch both channels at every edge
    always @(posedge clk)
    begin
        kot_out_t want;
        if (rst_n) begin
            if (src_valid && src_ready)
                lex_request(src_data);
            if (tok_valid && tok_ready) begin
                if (predicted_tokens.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected token, expected none, actual code %0d",
                             $time, tok_data.token_code);
                end
                else begin
                    want = predicted_tokens.pop_front();
                    check_field("token_code", want.token_code, tok_data.token_code);
                    check_field("number_value", want.number_value, tok_data.number_value);
                    check_field("number_saturated", want.number_saturated,
                                tok_data.number_saturated);
                    check_field("word_length", want.word_length, tok_data.word_length);
                    check_field("last_of_run", want.last_of_run, tok_data.last_of_run);
                end
            end
        end
        fail_count <= mismatches;
        tokens_due <= predicted_tokens.size();
    end

endmodule

[test/keyword_operator_tokenizer_test.sv]
// Top of the tokenizer testbench: clock, reset, character stimulus and final verdict.
`timescale 1ns / 1ps

module keyword_operator_tokenizer_test;
    import kot_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RANDOM_ITEMS    = 1350;
    localparam int STALL_CYCLES    = 300;
    localparam int SETTLE_CYCLES   = 10;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     src_valid = 1'b0;
    kot_in_t  src_data  = '0;
    logic     tok_ready = 1'b0;
    logic     src_ready;
    logic     tok_valid;
    kot_out_t tok_data;

    int       fail_count;
    int       tokens_due;
    int       sent_count  = 0;
    int       burst_left  = 0;
    int       cycle_count = 0;
    logic     stall_due   = 1'b0;

    string    kw_words [KW_COUNT] = '{"for", "if", "then", "else", "while", "do"};
    string    op_chars  = "#+-*/:<>=;()";
    string    op_pairs [4] = '{":=", "<>", "<=", ">="};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    keyword_operator_tokenizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_data  (tok_data)
    );

    keyword_operator_tokenizer_check lex_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_ready  (src_ready),
        .src_data   (src_data),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_data   (tok_data),
        .fail_count (fail_count),
        .tokens_due (tokens_due)
    );

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one request and hold it until accepted
    task send_item(logic [7:0] c, logic eot);
        kot_in_t item;
        item.char_code   = c;
        item.end_of_text = eot;
        src_valid <= 1'b1;
        src_data  <= item;
        @(posedge clk);
        while (!src_ready)
            @(posedge clk);
        sent_count++;
        if (sent_count == 400)
            stall_due <= 1'b1;
    endtask

    // Same, with bursts and random gaps between them
    task offer(logic [7:0] c, logic eot);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                src_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        send_item(c, eot);
    endtask

    task offer_text(string s);
        for (int i = 0; i < s.len(); i++)
            offer(s[i], 1'b0);
    endtask

    // Stop offering until every predicted token has come out
    task drain();
        src_valid <= 1'b0;
        do
            @(posedge clk);
        while (tokens_due != 0);
    endtask

    function logic [7:0] any_letter();
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function logic [7:0] any_digit();
        return 8'($urandom_range(CH_ZERO, CH_NINE));
    endfunction

    function logic [7:0] any_delimiter();
        int n;
        n = $urandom_range(0, 2);
        return (n == 0) ? CH_SPACE : ((n == 1) ? CH_CR : CH_LF);
    endfunction

    // One random lexeme: mostly well-formed pieces, some noise
    task offer_lexeme();
        logic [7:0] run [$];
        string      s;
        int         pick;
        int         n;
        pick = $urandom_range(0, 8);
        case (pick)
            0, 1:
            begin
                s = kw_words[$urandom_range(0, KW_COUNT - 1)];
                for (int i = 0; i < s.len(); i++)
                    run.push_back(s[i]);
                n = $urandom_range(0, 3);
                if (n == 0)
                    run.push_back(any_letter());
                else if (n == 1)
                    void'(run.pop_back());
            end
            2:
            begin
                run.push_back(any_letter());
                repeat ($urandom_range(0, 8))
                    run.push_back(($urandom_range(0, 2) == 0) ? any_digit() : any_letter());
            end
            3:
            begin
                n = $urandom_range(0, 5);
                s = (n == 0) ? "4294967295" : ((n == 1) ? "4294967296" : "");
                for (int i = 0; i < s.len(); i++)
                    run.push_back(s[i]);
                if (s.len() == 0)
                    repeat ($urandom_range(1, 12))
                        run.push_back(any_digit());
            end
            4, 5:
            begin
                n = $urandom_range(0, 15);
                if (n < 12)
                    run.push_back(op_chars[n]);
                else
                begin
                    run.push_back(op_pairs[n - 12][0]);
                    run.push_back(op_pairs[n - 12][1]);
                end
            end
            6:
                repeat ($urandom_range(1, 3))
                    run.push_back(any_delimiter());
            7:
                repeat ($urandom_range(1, 3))
                    run.push_back(8'($urandom_range(0, 255)));
            default:
                offer(8'($urandom_range(0, 255)), 1'b1);
        endcase
        // words are often followed by a delimiter
        if (pick <= 3 && $urandom_range(0, 1) == 0)
            run.push_back(any_delimiter());
        foreach (run[i])
            offer(run[i], 1'b0);
    endtask

    // Receiver: stall pattern of its own, plus one long hold-off
    initial
    begin
        int   mode;
        int   span;
        logic stall_done;
        stall_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span)
            begin
                if (stall_due && !stall_done)
                begin
                    stall_done = 1'b1;
                    tok_ready <= 1'b0;
                    repeat (STALL_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       tok_ready <= 1'b1;
                    1:       tok_ready <= 1'($urandom_range(0, 1));
                    2:       tok_ready <= ($urandom_range(0, 3) == 0);
                    default: tok_ready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Sender and verdict
    initial
    begin
        int   target;
        logic paused;
        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keyword ended by an operator, pairs, flush, odd bytes, broken pair
        offer_text("while#9<=");
        offer(8'h00, 1'b1);
        offer_text("do>");
        offer(8'hFF, 1'b1);
        offer(8'h00, 1'b0);
        offer(8'hFF, 1'b0);
        offer(CH_CR, 1'b0);
        offer_text("if:y<>(");
        offer(8'hA5, 1'b1);
        offer(8'h5A, 1'b1);

        // Random text
        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target)
        begin
            if (!paused && sent_count >= 600)
            begin
                paused = 1'b1;
                drain();
            end
            offer_lexeme();
        end
        offer(8'h00, 1'b1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
